FILE: hdl/slefr_pkg.sv
`timescale 1ns / 1ps

package slefr_pkg;

  // frame phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_KIND    = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5,
    PH_END     = 3'd6
  } phase_t;

  // configuration register indexes
  localparam logic [0:0] REG_START_BYTE = 1'b0;
  localparam logic [0:0] REG_END_BYTE   = 1'b1;

  localparam logic [7:0] START_BYTE_RESET = 8'hAA;
  localparam logic [7:0] END_BYTE_RESET   = 8'hBB;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 11;
  localparam int LEN_W   = 16;
  // wide enough for header + longest length + longest trailer + 1
  localparam int SUM_W   = LEN_W + 2;
  // start, kind and two length bytes come before the payload
  localparam int HDR_LEN = 4;

endpackage

FILE: hdl/sof_length_eof_frame_receiver_core.sv
`timescale 1ns / 1ps
// output: a byte's result is registered and appears in the cycle after its transaction
// throughput: one byte per cycle, limited only by the single result register
//   (input is ready whenever the result register is empty or being drained)
// reset: rst is synchronous, active high; returns to hunting for the start
//   byte and reloads start byte 0xAA and end byte 0xBB
module sof_length_eof_frame_receiver_core #(
  parameter int MAX_PAYLOAD   = 1024,
  parameter int TRAILER_BYTES = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [7:0]               cfg_data,
  // received bytes
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  // results
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [10:0]              byte_index,
  output logic [7:0]               byte_value,
  output logic                     frame_done,
  output logic                     frame_abort,
  output logic [7:0]               packet_kind,
  output logic [10:0]              payload_count
);
  import slefr_pkg::*;

  // position counter must reach header + max payload + trailer + 1, and is
  // kept at least as wide as the reported index
  localparam int POS_RAW = $clog2(MAX_PAYLOAD + TRAILER_BYTES + HDR_LEN + 2);
  localparam int POS_W   = (POS_RAW > IDX_W) ? POS_RAW : IDX_W;

  // configuration registers
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;

  // frame state
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [BYTE_W-1:0] len_lo, len_lo_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [BYTE_W-1:0] kind, kind_next;

  // result produced for the byte being taken
  logic              emit;
  logic [IDX_W-1:0]  res_index;
  logic              res_done;
  logic              res_abort;
  logic [BYTE_W-1:0] res_kind;
  logic [IDX_W-1:0]  res_count;

  logic              accept;
  logic [LEN_W-1:0]  len_full;
  logic [SUM_W-1:0]  pos_inc;
  logic [SUM_W-1:0]  payload_end;
  logic [SUM_W-1:0]  trailer_end;
  phase_t            after_payload;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // length as it stands once the high byte arrives
  assign len_full    = {rx_byte, len_lo};
  assign pos_inc     = SUM_W'(pos) + SUM_W'(1);
  assign payload_end = SUM_W'(len) + SUM_W'(HDR_LEN);
  assign trailer_end = payload_end + SUM_W'(TRAILER_BYTES);
  // with no trailer the end byte follows the payload straight away
  assign after_payload = (TRAILER_BYTES > 0) ? PH_TRAILER : PH_END;

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    len_lo_next = len_lo;
    len_next    = len;
    kind_next   = kind;
    emit        = 1'b1;
    res_index   = pos[IDX_W-1:0];
    res_done    = 1'b0;
    res_abort   = 1'b0;
    res_kind    = '0;
    res_count   = '0;
    unique case (phase)
      PH_KIND: begin
        kind_next  = rx_byte;
        pos_next   = pos + POS_W'(1);
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo_next = rx_byte;
        pos_next    = pos + POS_W'(1);
        phase_next  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_next = len_full;
        if (len_full > LEN_W'(MAX_PAYLOAD)) begin
          // oversize length, drop the frame
          res_abort  = 1'b1;
          pos_next   = '0;
          phase_next = PH_HUNT;
        end else begin
          pos_next   = pos + POS_W'(1);
          // zero length skips the payload
          phase_next = (len_full == '0) ? after_payload : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pos_next = pos + POS_W'(1);
        if (pos_inc >= payload_end) begin
          phase_next = after_payload;
        end
      end
      PH_TRAILER: begin
        // trailer check bytes pass through unverified
        pos_next = pos + POS_W'(1);
        if (pos_inc >= trailer_end) begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        if (rx_byte == end_byte) begin
          res_done  = 1'b1;
          res_kind  = kind;
          res_count = len[IDX_W-1:0];
        end else begin
          // bad end byte is not retried as a start byte
          res_abort = 1'b1;
        end
        pos_next   = '0;
        phase_next = PH_HUNT;
      end
      default: begin
        // hunting for the start byte
        phase_next = PH_HUNT;
        if (rx_byte == start_byte) begin
          res_index   = '0;
          pos_next    = POS_W'(1);
          len_lo_next = '0;
          len_next    = '0;
          kind_next   = '0;
          phase_next  = PH_KIND;
        end else begin
          emit     = 1'b0;
          pos_next = '0;
        end
      end
    endcase
  end

  // configuration writes are registered and apply to bytes taken after the write
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      end_byte   <= END_BYTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // frame state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      pos    <= '0;
      len_lo <= '0;
      len    <= '0;
      kind   <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      pos    <= pos_next;
      len_lo <= len_lo_next;
      len    <= len_next;
      kind   <= kind_next;
    end
  end

  // result register, refilled in the same cycle it is drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      byte_index    <= res_index;
      byte_value    <= rx_byte;
      frame_done    <= res_done;
      frame_abort   <= res_abort;
      packet_kind   <= res_kind;
      payload_count <= res_count;
    end
  end

endmodule

FILE: hdl/slefr_checker.sv
`timescale 1ns / 1ps
module slefr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] byte_index,
  input logic [7:0]  byte_value,
  input logic        frame_done,
  input logic        frame_abort,
  input logic [7:0]  packet_kind,
  input logic [10:0] payload_count
);

  // a frame ends either good or aborted, never both
  a_done_abort_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && frame_abort))
    else $error("frame_done and frame_abort together");

  // type and length are only reported with a completed frame
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (packet_kind == 8'd0 && payload_count == 11'd0))
    else $error("frame summary outside frame_done");

  // after a frame ends the next result is a start byte
  a_restart_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && (frame_done || frame_abort)) |=>
      (!out_valid || byte_index == 11'd0))
    else $error("frame did not restart at position 0");

  // with the result register empty the input must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(byte_index)
      && $stable(byte_value)))
    else $error("stalled result changed");

endmodule

bind sof_length_eof_frame_receiver_core slefr_checker u_slefr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .byte_index    (byte_index),
  .byte_value    (byte_value),
  .frame_done    (frame_done),
  .frame_abort   (frame_abort),
  .packet_kind   (packet_kind),
  .payload_count (payload_count)
);
